FILE: rtl/core/irn_pkg.sv
// shared types, letter codes and the microcode table of the roman numeral converter
`default_nettype none

package irn_pkg;

	localparam int unsigned VALUE_W  = 12;
	localparam int unsigned SYMBOL_W = 7;
	localparam int unsigned WEIGHT_W = 10;
	localparam int unsigned PC_W     = 5;

	// ascii codes of the numeral letters
	localparam logic [SYMBOL_W-1:0] LTR_NONE = 7'h00;
	localparam logic [SYMBOL_W-1:0] LTR_I    = 7'h49;
	localparam logic [SYMBOL_W-1:0] LTR_V    = 7'h56;
	localparam logic [SYMBOL_W-1:0] LTR_X    = 7'h58;
	localparam logic [SYMBOL_W-1:0] LTR_L    = 7'h4C;
	localparam logic [SYMBOL_W-1:0] LTR_C    = 7'h43;
	localparam logic [SYMBOL_W-1:0] LTR_D    = 7'h44;
	localparam logic [SYMBOL_W-1:0] LTR_M    = 7'h4D;

	// step kinds: compare and emit the first letter, or emit the trailing letter
	typedef enum logic {
		OP_TEST,
		OP_SECOND
	} op_t;

	// one control word
	typedef struct packed {
		op_t                 op;
		logic                two_letter;
		logic [WEIGHT_W-1:0] weight;
		logic [SYMBOL_W-1:0] letter;
		logic [PC_W-1:0]     pass_pc;
		logic [PC_W-1:0]     fail_pc;
	} ucode_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic fits;
		logic rest_zero;
		logic diff_zero;
	} dp_stat_t;

	// one character leaving the sequencer
	typedef struct packed {
		logic                emit;
		logic [SYMBOL_W-1:0] symbol;
		logic                last;
		logic                empty;
	} emit_t;

	function automatic ucode_t mk(input op_t op, input logic two, input logic [WEIGHT_W-1:0] w,
			input logic [SYMBOL_W-1:0] ltr, input logic [PC_W-1:0] pass_pc,
			input logic [PC_W-1:0] fail_pc);
		ucode_t u;
		u.op         = op;
		u.two_letter = two;
		u.weight     = w;
		u.letter     = ltr;
		u.pass_pc    = pass_pc;
		u.fail_pc    = fail_pc;
		return u;
	endfunction

	// microcode program: one test step per table entry, plus a second-letter step
	// after each subtractive pair that jumps back to retry its entry
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t u;
		case (pc)
			5'd0:    u = mk(OP_TEST,   1'b0, 10'd1000, LTR_M, 5'd0,  5'd1);
			5'd1:    u = mk(OP_TEST,   1'b1, 10'd900,  LTR_C, 5'd2,  5'd3);
			5'd2:    u = mk(OP_SECOND, 1'b0, 10'd0,    LTR_M, 5'd1,  5'd1);
			5'd3:    u = mk(OP_TEST,   1'b0, 10'd500,  LTR_D, 5'd3,  5'd4);
			5'd4:    u = mk(OP_TEST,   1'b1, 10'd400,  LTR_C, 5'd5,  5'd6);
			5'd5:    u = mk(OP_SECOND, 1'b0, 10'd0,    LTR_D, 5'd4,  5'd4);
			5'd6:    u = mk(OP_TEST,   1'b0, 10'd100,  LTR_C, 5'd6,  5'd7);
			5'd7:    u = mk(OP_TEST,   1'b1, 10'd90,   LTR_X, 5'd8,  5'd9);
			5'd8:    u = mk(OP_SECOND, 1'b0, 10'd0,    LTR_C, 5'd7,  5'd7);
			5'd9:    u = mk(OP_TEST,   1'b0, 10'd50,   LTR_L, 5'd9,  5'd10);
			5'd10:   u = mk(OP_TEST,   1'b1, 10'd40,   LTR_X, 5'd11, 5'd12);
			5'd11:   u = mk(OP_SECOND, 1'b0, 10'd0,    LTR_L, 5'd10, 5'd10);
			5'd12:   u = mk(OP_TEST,   1'b0, 10'd10,   LTR_X, 5'd12, 5'd13);
			5'd13:   u = mk(OP_TEST,   1'b1, 10'd9,    LTR_I, 5'd14, 5'd15);
			5'd14:   u = mk(OP_SECOND, 1'b0, 10'd0,    LTR_X, 5'd13, 5'd13);
			5'd15:   u = mk(OP_TEST,   1'b0, 10'd5,    LTR_V, 5'd15, 5'd16);
			5'd16:   u = mk(OP_TEST,   1'b1, 10'd4,    LTR_I, 5'd17, 5'd18);
			5'd17:   u = mk(OP_SECOND, 1'b0, 10'd0,    LTR_V, 5'd16, 5'd16);
			5'd18:   u = mk(OP_TEST,   1'b0, 10'd1,    LTR_I, 5'd18, 5'd18);
			default: u = mk(OP_TEST,   1'b0, 10'd1,    LTR_I, 5'd18, 5'd18);
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/irn_dp.sv
// remainder register with its compare and subtract
`default_nettype none

module irn_dp
	import irn_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                load,
	input  wire logic [VALUE_W-1:0]  value,
	input  wire logic                sub,
	input  wire ucode_t              ctrl,
	output dp_stat_t                 stat
);

	logic [VALUE_W-1:0] rest_q;
	logic [VALUE_W-1:0] weight_ext;
	logic [VALUE_W-1:0] diff;

	// compare and subtract against the current table weight
	always_comb begin
		weight_ext     = {{(VALUE_W-WEIGHT_W){1'b0}}, ctrl.weight};
		diff           = rest_q - weight_ext;
		stat.fits      = rest_q >= weight_ext;
		stat.rest_zero = rest_q == '0;
		stat.diff_zero = diff == '0;
	end

	// remainder
	always_ff @(posedge clk) begin
		if (load) begin
			rest_q <= value;
		end else if (sub) begin
			rest_q <= diff;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/irn_seq.sv
// microcode sequencer: step counter, control word fetch and jump logic
`default_nettype none

module irn_seq
	import irn_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     room,
	input  wire dp_stat_t stat,
	output ucode_t        ctrl,
	output logic          sub,
	output emit_t         emit,
	output logic          busy
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic            busy_q;
	logic            busy_d;

	assign ctrl = ucode_rom(pc_q);
	assign busy = busy_q;

	// decode the current step
	always_comb begin
		pc_d        = pc_q;
		busy_d      = busy_q;
		sub         = 1'b0;
		emit.emit   = 1'b0;
		emit.symbol = ctrl.letter;
		emit.last   = 1'b0;
		emit.empty  = 1'b0;
		if (start) begin
			pc_d   = '0;
			busy_d = 1'b1;
		end else if (busy_q) begin
			case (ctrl.op)
				OP_TEST: begin
					if (stat.rest_zero) begin
						// zero input: a single empty transfer
						emit.emit   = room;
						emit.symbol = LTR_NONE;
						emit.last   = 1'b1;
						emit.empty  = 1'b1;
						busy_d      = !room;
					end else if (stat.fits) begin
						emit.emit = room;
						emit.last = !ctrl.two_letter && stat.diff_zero;
						sub       = room;
						if (room) begin
							pc_d   = ctrl.pass_pc;
							busy_d = !emit.last;
						end
					end else begin
						pc_d = ctrl.fail_pc;
					end
				end
				OP_SECOND: begin
					emit.emit = room;
					emit.last = stat.rest_zero;
					if (room) begin
						pc_d   = ctrl.pass_pc;
						busy_d = !emit.last;
					end
				end
				default: begin
					busy_d = 1'b0;
				end
			endcase
		end
	end

	// step counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			busy_q <= 1'b0;
		end else begin
			pc_q   <= pc_d;
			busy_q <= busy_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/integer_to_roman_numeral.sv
// top level of the integer to roman numeral converter
//
// Input channel: in_valid / in_stall with the 12-bit value. Output channel:
// out_valid / out_stall carrying one ASCII letter per transfer in symbol,
// with last on the final letter. A zero value gives one transfer with
// empty_res and last set and symbol 0.
// A microcode sequencer walks the 13-entry greedy table, one step per cycle
// while no letter step waits on the output: each letter takes one step and
// each table entry that no longer fits takes one step. An input transfer
// loads the remainder register and sets busy; the sequencer then emits the
// first letter into the output register.
// in_stall is high while an item is being converted; one item at a time.
// Letters go through a single output register; when out_stall holds it
// full, a step that would emit a letter waits and nothing is lost.
// Reset (arst_n low) returns the sequencer to idle and empties the output
// register; an item in progress is dropped.
`default_nettype none

module integer_to_roman_numeral
	import irn_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [VALUE_W-1:0]  value,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [SYMBOL_W-1:0]      symbol,
	output logic                     last,
	output logic                     empty_res
);

	logic                start;
	logic                room;
	logic                sub;
	logic                busy;
	ucode_t              ctrl;
	dp_stat_t            stat;
	emit_t               emit;
	logic                out_valid_q;
	logic [SYMBOL_W-1:0] symbol_q;
	logic                last_q;
	logic                empty_q;

	// input transfer and output register space
	assign in_stall = busy;
	assign start    = in_valid && !busy;
	assign room     = !out_valid_q || !out_stall;

	irn_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.room   (room),
		.stat   (stat),
		.ctrl   (ctrl),
		.sub    (sub),
		.emit   (emit),
		.busy   (busy)
	);

	irn_dp u_dp (
		.clk   (clk),
		.load  (start),
		.value (value),
		.sub   (sub),
		.ctrl  (ctrl),
		.stat  (stat)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit.emit) begin
			symbol_q <= emit.symbol;
			last_q   <= emit.last;
			empty_q  <= emit.empty;
		end
	end

	assign out_valid = out_valid_q;
	assign symbol    = symbol_q;
	assign last      = last_q;
	assign empty_res = empty_q;

endmodule

`default_nettype wire

FILE: rtl/core/irn_checker.sv
// port-level checks for the roman numeral converter and their bind
`default_nettype none

module irn_checker
	import irn_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic [VALUE_W-1:0]  value,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic [SYMBOL_W-1:0] symbol,
	input wire logic                last,
	input wire logic                empty_res
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(symbol) && $stable(last)
			&& $stable(empty_res))
		else $error("stalled result changed");

	// the empty result is alone and carries no letter
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && empty_res |-> last && symbol == LTR_NONE)
		else $error("empty result malformed");

	// a non-empty result is a numeral letter
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !empty_res |-> symbol == LTR_I || symbol == LTR_V || symbol == LTR_X
			|| symbol == LTR_L || symbol == LTR_C || symbol == LTR_D || symbol == LTR_M)
		else $error("result is not a numeral letter");

	// an accepted value keeps the input stalled while it converts
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transfer");

	// once a zero value is taken, an output that is valid and empty carries last
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && value == '0 |=> !out_valid || !empty_res || last)
		else $error("zero value result malformed");

endmodule

bind integer_to_roman_numeral irn_checker u_irn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.value     (value),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.symbol    (symbol),
	.last      (last),
	.empty_res (empty_res)
);

`default_nettype wire

FILE: sim/tb_integer_to_roman_numeral.sv
// testbench for the integer to roman numeral converter: greedy-table predictor and letter checker
module tb_integer_to_roman_numeral;
	import irn_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HOLD_CYCLES  = 150;
	localparam int unsigned IDLE_LIMIT   = 5000;
	localparam int unsigned DRAIN_CYCLES = 40;

	// greedy table: weight, leading letter, trailing letter of subtractive pairs
	localparam int unsigned ROMAN_WEIGHT [13] = '{1000, 900, 500, 400, 100, 90, 50, 40,
		10, 9, 5, 4, 1};
	localparam logic [SYMBOL_W-1:0] ROMAN_HEAD [13] = '{LTR_M, LTR_C, LTR_D, LTR_C, LTR_C,
		LTR_X, LTR_L, LTR_X, LTR_X, LTR_I, LTR_V, LTR_I, LTR_I};
	localparam logic [SYMBOL_W-1:0] ROMAN_TAIL [13] = '{LTR_NONE, LTR_M, LTR_NONE, LTR_D,
		LTR_NONE, LTR_C, LTR_NONE, LTR_L, LTR_NONE, LTR_X, LTR_NONE, LTR_V, LTR_NONE};

	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic                last;
		logic                empty_res;
	} letter_t;

	typedef enum int unsigned {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [VALUE_W-1:0]  value     = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [SYMBOL_W-1:0] symbol;
	logic                last;
	logic                empty_res;

	letter_t     pending_letters [$];
	int unsigned errors       = 0;
	int unsigned burst_left   = 0;
	int unsigned max_gap      = 0;
	bit          hold_off_req = 1'b0;
	bit          drain        = 1'b0;

	integer_to_roman_numeral dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.symbol    (symbol),
		.last      (last),
		.empty_res (empty_res)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// queue the letters of one value's numeral
	function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
		letter_t     numeral [$];
		int unsigned rest;
		rest = 32'(v);
		if (rest == 0) begin
			pending_letters.push_back('{LTR_NONE, 1'b1, 1'b1});
			return;
		end
		for (int k = 0; k < 13; k++) begin
			while (rest >= ROMAN_WEIGHT[k]) begin
				rest -= ROMAN_WEIGHT[k];
				numeral.push_back('{ROMAN_HEAD[k], 1'b0, 1'b0});
				if (ROMAN_TAIL[k] != LTR_NONE) begin
					numeral.push_back('{ROMAN_TAIL[k], 1'b0, 1'b0});
				end
			end
		end
		numeral[numeral.size()-1].last = 1'b1;
		foreach (numeral[i]) pending_letters.push_back(numeral[i]);
	endfunction

	// offer one value until it is taken, then maybe pause between bursts
	task automatic send_value(input logic [VALUE_W-1:0] v);
		in_valid <= 1'b1;
		value    <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_numeral(v);
		if (burst_left != 0) begin
			burst_left--;
		end else if (max_gap != 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, max_gap)) @(posedge clk);
			burst_left = $urandom_range(0, 7);
		end
	endtask

	// output checker
	always @(posedge clk) begin
		letter_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_letters.size() == 0) begin
				$error("unexpected letter transfer: symbol %0d last %0b empty_res %0b",
					symbol, last, empty_res);
				errors++;
			end else begin
				want = pending_letters.pop_front();
				if (symbol !== want.symbol) begin
					$error("symbol mismatch: expected %0d, got %0d", want.symbol, symbol);
					errors++;
				end
				if (last !== want.last) begin
					$error("last mismatch: expected %0b, got %0b", want.last, last);
					errors++;
				end
				if (empty_res !== want.empty_res) begin
					$error("empty_res mismatch: expected %0b, got %0b", want.empty_res,
						empty_res);
					errors++;
				end
			end
		end
	end

	// receiver stall pattern, with a long hold-off on request
	initial begin : receiver
		stall_mode_t mode;
		int unsigned stretch;
		int unsigned phase;
		mode    = STALL_NONE;
		stretch = 0;
		phase   = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (drain) begin
				out_stall <= 1'b0;
			end else begin
				if (stretch == 0) begin
					mode    = stall_mode_t'($urandom_range(0, 3));
					stretch = $urandom_range(20, 80);
				end
				stretch--;
				phase++;
				case (mode)
					STALL_NONE:     out_stall <= 1'b0;
					STALL_RANDOM:   out_stall <= ($urandom_range(0, 1) == 1);
					STALL_PERIODIC: out_stall <= (phase % 3 == 0);
					default:        out_stall <= ($urandom_range(0, 4) != 0);
				endcase
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin : watchdog
		int unsigned idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
			else idle++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// table boundaries, subtractive pairs, zero, longest numeral, out-of-range values
	task automatic test_corner_values();
		int unsigned corners [$] = '{0, 1, 3, 4, 5, 9, 10, 40, 49, 90, 99, 400, 444,
			500, 900, 999, 1000, 1994, 2048, 3888, 3999, 4000, 4088, 4095, 0};
		max_gap = 6;
		foreach (corners[i]) send_value(VALUE_W'(corners[i]));
	endtask

	// no sender gaps, items offered every cycle while the input is not stalled
	task automatic test_back_to_back();
		max_gap    = 0;
		burst_left = 0;
		repeat (16) send_value(VALUE_W'($urandom_range(0, 3999)));
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_output_hold();
		max_gap      = 2;
		hold_off_req = 1'b1;
		repeat (10) send_value(VALUE_W'($urandom_range(1000, 3999)));
		while (hold_off_req) @(posedge clk);
	endtask

	// random values weighted toward zero, small numbers and the region above 3999
	task automatic test_random_values();
		logic [VALUE_W-1:0] v;
		int unsigned        pick;
		max_gap = 12;
		repeat (110) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) v = '0;
			else if (pick < 18) v = VALUE_W'($urandom_range(4000, 4095));
			else if (pick < 33) v = VALUE_W'($urandom_range(1, 50));
			else if (pick < 43) v = VALUE_W'($urandom);
			else v = VALUE_W'($urandom_range(1, 3999));
			send_value(v);
		end
	endtask

	// sequence of tests, then drain and report
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_values();
		test_back_to_back();
		test_output_hold();
		test_random_values();
		in_valid <= 1'b0;
		drain = 1'b1;
		while (pending_letters.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
